>>> hdl/phong_light_shader_macros.svh
// ----------------------------------------------------------------------------
// Phong light shader assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PHONG_LIGHT_SHADER_MACROS_SVH
`define PHONG_LIGHT_SHADER_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define PLS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// Phong light shader package
// Fixed-point formats, pipeline latencies and the exp2 constant generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CB   = COMPONENT_BITS;
    localparam int VF   = CB - 2;          // vector fraction bits
    localparam int VECW = 3 * CB;          // packed vector width
    localparam int PW   = 2 * CB;          // component product
    localparam int RAWW = 2 * CB + 2;      // sum of three products
    localparam int NDLW = CB + 4;          // N.L
    localparam int MW   = 2 * CB + 5;      // 2*ndl*n
    localparam int RFW  = CB + 8;          // reflected component
    localparam int VRW  = 2 * CB + 8;      // v*r product
    localparam int DVRW = 2 * CB + 10;     // V.R
    localparam int VVW  = 2 * CB;          // V.V
    localparam int LENW = CB;              // view vector length
    localparam int COSW = VF + 1;          // cosine, 0 .. one
    localparam int IDW  = 38;              // diffuse intensity, Q30
    localparam int ISPW = 34;              // specular intensity, Q30
    localparam int PWRW = 31;              // power result, Q1.30
    localparam int LOG_BITS  = 16;
    localparam int EXP_BITS  = 16;
    localparam int SHIN_FRAC = 6;

    localparam int LAT_DIV = CB + VF + 3;
    localparam int LAT_POW = LOG_BITS + EXP_BITS + 5;

    localparam logic [PWRW-1:0] PWR_ONE = PWRW'(1) << 30;
    localparam logic [15:0]     ONE_Q15 = 16'h8000;

    function automatic logic [63:0] isqrt_const(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = x;
        res = '0;
        b   = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-idx) in Q0.30, each root truncated as the chain goes down.
    function automatic logic [29:0] exp_const(input int idx);
        logic [63:0] c;
        c = isqrt_const(64'h1 << 59);
        for (int j = 2; j <= idx; j++) begin
            c = isqrt_const(c << 30);
        end
        return c[29:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/pls_lendiv.sv
// ----------------------------------------------------------------------------
// Phong light shader view cosine
// Pipelined square root of V.V, then restoring division of V.R by it,
// one result bit per stage, zero unless both are positive, saturated to one.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_lendiv (
    input  logic                              clk,
    input  logic [pls_pkg::VVW-1:0]           vv,
    input  logic signed [pls_pkg::DVRW-1:0]   dvr,
    output logic [pls_pkg::COSW-1:0]          cos_out
);
    import pls_pkg::*;

    localparam int RW = CB + VF + 1;

    logic [VVW-1:0]         x_reg   [CB];
    logic [VVW-1:0]         res_reg [CB];
    logic signed [DVRW-1:0] dv_reg  [CB];

    genvar j;
    for (j = 0; j < CB; j++) begin : g_sqrt
        localparam logic [VVW-1:0] BIT = VVW'(1) << (VVW - 2 - 2 * j);
        logic [VVW-1:0]         x_in;
        logic [VVW-1:0]         res_in;
        logic signed [DVRW-1:0] dv_in;
        logic [VVW-1:0]         x_next;
        logic [VVW-1:0]         res_next;
        if (j == 0) begin : g_first
            assign x_in   = vv;
            assign res_in = '0;
            assign dv_in  = dvr;
        end else begin : g_rest
            assign x_in   = x_reg[j-1];
            assign res_in = res_reg[j-1];
            assign dv_in  = dv_reg[j-1];
        end
        always_comb
        begin
            if (x_in >= res_in + BIT) begin
                x_next   = x_in - (res_in + BIT);
                res_next = (res_in >> 1) + BIT;
            end else begin
                x_next   = x_in;
                res_next = res_in >> 1;
            end
        end
        always_ff @(posedge clk)
        begin
            x_reg[j]   <= x_next;
            res_reg[j] <= res_next;
            dv_reg[j]  <= dv_in;
        end
    end

    // Division setup: quotients of two or more saturate at once.
    logic [LENW-1:0] len;
    logic            pos_reg;
    logic            ovf_reg;
    logic [LENW-1:0] len_reg;
    logic [RW-1:0]   rem0_reg;

    assign len = res_reg[CB-1][LENW-1:0];

    always_ff @(posedge clk)
    begin
        pos_reg  <= (len != '0) && !dv_reg[CB-1][DVRW-1] && (dv_reg[CB-1] != '0);
        ovf_reg  <= $unsigned(dv_reg[CB-1]) >= (DVRW'(len) << (VF + 1));
        len_reg  <= len;
        rem0_reg <= dv_reg[CB-1][RW-1:0];
    end

    logic [RW-1:0]   rem_reg [VF+1];
    logic [COSW-1:0] q_reg   [VF+1];
    logic [LENW-1:0] dl_reg  [VF+1];
    logic            pos_d_reg [VF+1];
    logic            ovf_d_reg [VF+1];

    genvar s;
    for (s = 0; s <= VF; s++) begin : g_div
        localparam int SH = VF - s;
        logic [RW-1:0]   rem_in;
        logic [COSW-1:0] q_in;
        logic [LENW-1:0] l_in;
        logic            p_in;
        logic            o_in;
        logic [RW-1:0]   sub;
        logic [RW-1:0]   rem_next;
        logic [COSW-1:0] q_next;
        if (s == 0) begin : g_first
            assign rem_in = rem0_reg;
            assign q_in   = '0;
            assign l_in   = len_reg;
            assign p_in   = pos_reg;
            assign o_in   = ovf_reg;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign l_in   = dl_reg[s-1];
            assign p_in   = pos_d_reg[s-1];
            assign o_in   = ovf_d_reg[s-1];
        end
        assign sub = RW'(l_in) << SH;
        always_comb
        begin
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_in >= sub) begin
                rem_next   = rem_in - sub;
                q_next[SH] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            rem_reg[s]   <= rem_next;
            q_reg[s]     <= q_next;
            dl_reg[s]    <= l_in;
            pos_d_reg[s] <= p_in;
            ovf_d_reg[s] <= o_in;
        end
    end

    localparam logic [COSW-1:0] COS_ONE = COSW'(1) << VF;

    logic [COSW-1:0] cos_reg;
    logic [COSW-1:0] cos_next;

    always_comb
    begin
        if (!pos_d_reg[VF]) begin
            cos_next = '0;
        end else if (ovf_d_reg[VF] || (q_reg[VF] > COS_ONE)) begin
            cos_next = COS_ONE;
        end else begin
            cos_next = q_reg[VF];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
    end

    assign cos_out = cos_reg;

endmodule

`default_nettype wire

>>> hdl/pls_power.sv
// ----------------------------------------------------------------------------
// Phong light shader power unit
// cos^shininess as exp2(-shininess * -log2(cos)), log2 by repeated squaring
// and exp2 by a product of fixed roots of two, one step per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_power (
    input  logic                        clk,
    input  logic [pls_pkg::COSW-1:0]    cos_in,
    input  logic [15:0]                 shin,
    output logic [pls_pkg::PWRW-1:0]    pwr
);
    import pls_pkg::*;

    typedef struct packed {
        logic        zero;
        logic        full;
        logic [4:0]  base;
        logic [15:0] shin;
    } lg_t;

    typedef struct packed {
        logic        zero;
        logic        under;
        logic        shin_zero;
        logic [4:0]  k;
        logic [15:0] f;
    } ex_t;

    // Normalize: a in Q1.16, mantissa y in [1,2) as Q1.15.
    logic [COSW+15:0] a_wide;
    logic [16:0]      a;
    logic [3:0]       p;
    logic [15:0]      y_next;
    lg_t              lg_next;

    always_comb
    begin
        a_wide = {cos_in, 16'h0000} >> VF;
        a      = a_wide[16:0];
        p      = '0;
        for (int i = 0; i < 16; i++) begin
            if (a[i]) begin
                p = 4'(i);
            end
        end
        y_next       = a[15:0] << (4'd15 - p);
        lg_next.zero = (cos_in == '0);
        lg_next.full = a[16];
        lg_next.base = 5'd16 - {1'b0, p};
        lg_next.shin = shin;
    end

    logic [15:0]         y_reg    [LOG_BITS+1];
    logic [LOG_BITS-1:0] frac_reg [LOG_BITS+1];
    lg_t                 lg_reg   [LOG_BITS+1];

    always_ff @(posedge clk)
    begin
        y_reg[0]    <= y_next;
        frac_reg[0] <= '0;
        lg_reg[0]   <= lg_next;
    end

    genvar s;
    for (s = 0; s < LOG_BITS; s++) begin : g_log
        logic [31:0]         sq;
        logic [15:0]         ys_next;
        logic [LOG_BITS-1:0] fr_next;
        always_comb
        begin
            sq      = y_reg[s] * y_reg[s];
            fr_next = frac_reg[s];
            if (sq[31]) begin
                ys_next                       = sq[31:16];
                fr_next[LOG_BITS - 1 - s]     = 1'b1;
            end else begin
                ys_next = sq[30:15];
            end
        end
        always_ff @(posedge clk)
        begin
            y_reg[s+1]    <= ys_next;
            frac_reg[s+1] <= fr_next;
            lg_reg[s+1]   <= lg_reg[s];
        end
    end

    logic [20:0] lneg_reg;
    logic        zero_l_reg;
    logic [15:0] shin_l_reg;

    always_ff @(posedge clk)
    begin
        lneg_reg   <= lg_reg[LOG_BITS].full ? '0
                    : ({lg_reg[LOG_BITS].base, 16'h0000} - 21'(frac_reg[LOG_BITS]));
        zero_l_reg <= lg_reg[LOG_BITS].zero;
        shin_l_reg <= lg_reg[LOG_BITS].shin;
    end

    logic [36:0] eprod;
    logic [30:0] e_reg;
    logic        zero_e_reg;
    logic        shinz_e_reg;

    assign eprod = lneg_reg * shin_l_reg;

    always_ff @(posedge clk)
    begin
        e_reg       <= eprod[36:SHIN_FRAC];
        zero_e_reg  <= zero_l_reg;
        shinz_e_reg <= (shin_l_reg == '0);
    end

    ex_t              ex_reg [EXP_BITS+1];
    logic [PWRW-1:0]  r_reg  [EXP_BITS+1];
    ex_t              ex_next;

    always_comb
    begin
        ex_next.zero      = zero_e_reg;
        ex_next.under     = (e_reg[30:16] >= 15'd31);
        ex_next.shin_zero = shinz_e_reg;
        ex_next.k         = e_reg[20:16];
        ex_next.f         = e_reg[15:0];
    end

    always_ff @(posedge clk)
    begin
        ex_reg[0] <= ex_next;
        r_reg[0]  <= PWR_ONE;
    end

    genvar i;
    for (i = 0; i < EXP_BITS; i++) begin : g_exp
        localparam logic [29:0] CI = exp_const(i + 1);
        logic [PWRW+29:0] prod;
        logic [PWRW-1:0]  r_next;
        always_comb
        begin
            prod = r_reg[i] * CI;
            if (ex_reg[i].f[EXP_BITS - 1 - i]) begin
                r_next = prod[PWRW+29:30];
            end else begin
                r_next = r_reg[i];
            end
        end
        always_ff @(posedge clk)
        begin
            r_reg[i+1]  <= r_next;
            ex_reg[i+1] <= ex_reg[i];
        end
    end

    logic [PWRW-1:0] pwr_reg;

    always_ff @(posedge clk)
    begin
        if (ex_reg[EXP_BITS].shin_zero) begin
            pwr_reg <= PWR_ONE;
        end else if (ex_reg[EXP_BITS].zero || ex_reg[EXP_BITS].under) begin
            pwr_reg <= '0;
        end else begin
            pwr_reg <= r_reg[EXP_BITS] >> ex_reg[EXP_BITS].k;
        end
    end

    assign pwr = pwr_reg;

endmodule

`default_nettype wire

>>> hdl/phong_light_shader.sv
// ----------------------------------------------------------------------------
// Phong light shader
// One surface point lit by one light per item: ambient plus clamped diffuse
// and specular terms, fixed point throughout.
//
//   Channel   Signals                                  Transfer
//   input     start, busy, normal_vec .. shininess     start high, busy low
//   result    done, red_out, green_out, blue_out       done high, one cycle
//
// A new item is taken every cycle; busy stays low.
// Each item passes the input and datapath stages, the bit-per-stage
// square root and divider, the sixteen squaring and sixteen exp2
// product stages, and the tail stages before done is raised.
// Reset clears only the valid bits; the datapath flushes by itself.
// Results cannot be held off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "phong_light_shader_macros.svh"

module phong_light_shader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] normal_vec,
    input  logic [47:0] view_vec,
    input  logic [47:0] light_vec,
    input  logic [47:0] light_rgb,
    input  logic [47:0] surface_rgb,
    input  logic [47:0] ambient_rgb,
    input  logic [15:0] shadow_factor,
    input  logic [15:0] diffuse_weight,
    input  logic [15:0] specular_weight,
    input  logic [15:0] shininess,
    output logic        done,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out
);
    import pls_pkg::*;

    typedef struct packed {
        logic             lit;
        logic [47:0]      lrgb;
        logic [47:0]      amb;
        logic [2:0][16:0] colp;
        logic [IDW-1:0]   idiff;
        logic [15:0]      ks;
        logic [15:0]      shadow;
        logic [15:0]      shin;
    } side_t;

    localparam int DLN = LAT_DIV + LAT_POW;

    assign busy = 1'b0;

    // Stage 1: input capture.
    logic        v1_reg;
    logic [47:0] nw1_reg, vw1_reg, lw1_reg, lc1_reg, sc1_reg, am1_reg;
    logic [15:0] sh1_reg, kd1_reg, ks1_reg, sn1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        nw1_reg <= normal_vec;
        vw1_reg <= view_vec;
        lw1_reg <= light_vec;
        lc1_reg <= light_rgb;
        sc1_reg <= surface_rgb;
        am1_reg <= ambient_rgb;
        sh1_reg <= shadow_factor;
        kd1_reg <= diffuse_weight;
        ks1_reg <= specular_weight;
        sn1_reg <= shininess;
    end

    // Stage 2: unpack and form component products.
    logic [VECW-1:0]        nw, vw, lw;
    logic signed [CB-1:0]   n2_next [3], v2_next [3], l2_next [3];
    logic signed [CB-1:0]   n2_reg [3], v2_reg [3], l2_reg [3];
    logic signed [PW-1:0]   nl2_next [3], nl2_reg [3];
    logic [PW-1:0]          vs2_next [3], vs2_reg [3];
    logic [2:0][16:0]       colp2_next, colp2_reg;
    logic [31:0]            kdsh2_reg;
    logic [47:0]            lc2_reg, am2_reg;
    logic [15:0]            sh2_reg, ks2_reg, sn2_reg;
    logic                   v2_vld_reg;

    assign nw = VECW'(nw1_reg);
    assign vw = VECW'(vw1_reg);
    assign lw = VECW'(lw1_reg);

    always_comb
    begin
        logic [31:0] cp;
        for (int k = 0; k < 3; k++) begin
            n2_next[k]  = $signed(nw[(3 - k) * CB - 1 -: CB]);
            v2_next[k]  = $signed(vw[(3 - k) * CB - 1 -: CB]);
            l2_next[k]  = $signed(lw[(3 - k) * CB - 1 -: CB]);
            nl2_next[k] = PW'(n2_next[k] * l2_next[k]);
            vs2_next[k] = PW'(v2_next[k] * v2_next[k]);
            cp            = lc1_reg[(2 - k) * 16 +: 16] * sc1_reg[(2 - k) * 16 +: 16];
            colp2_next[k] = cp[31:15];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++) begin
            n2_reg[k]  <= n2_next[k];
            v2_reg[k]  <= v2_next[k];
            l2_reg[k]  <= l2_next[k];
            nl2_reg[k] <= nl2_next[k];
            vs2_reg[k] <= vs2_next[k];
        end
        colp2_reg <= colp2_next;
        kdsh2_reg <= kd1_reg * sh1_reg;
        lc2_reg   <= lc1_reg;
        am2_reg   <= am1_reg;
        sh2_reg   <= sh1_reg;
        ks2_reg   <= ks1_reg;
        sn2_reg   <= sn1_reg;
    end

    // Stage 3: N.L, V.V and the lit decision.
    logic signed [RAWW-1:0] raw3;
    logic signed [NDLW-1:0] ndl3_next, ndl3_reg;
    logic signed [CB-1:0]   n3_reg [3], v3_reg [3], l3_reg [3];
    logic [VVW-1:0]         vv3_reg;
    logic                   lit3_reg, v3_vld_reg;
    logic [2:0][16:0]       colp3_reg;
    logic [31:0]            kdsh3_reg;
    logic [47:0]            lc3_reg, am3_reg;
    logic [15:0]            sh3_reg, ks3_reg, sn3_reg;

    assign raw3      = RAWW'(nl2_reg[0]) + RAWW'(nl2_reg[1]) + RAWW'(nl2_reg[2]);
    assign ndl3_next = NDLW'(raw3 >>> VF);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++) begin
            n3_reg[k] <= n2_reg[k];
            v3_reg[k] <= v2_reg[k];
            l3_reg[k] <= l2_reg[k];
        end
        ndl3_reg  <= ndl3_next;
        vv3_reg   <= vs2_reg[0] + vs2_reg[1] + vs2_reg[2];
        lit3_reg  <= !ndl3_next[NDLW-1] && (ndl3_next != '0) && (sh2_reg != '0);
        colp3_reg <= colp2_reg;
        kdsh3_reg <= kdsh2_reg;
        lc3_reg   <= lc2_reg;
        am3_reg   <= am2_reg;
        sh3_reg   <= sh2_reg;
        ks3_reg   <= ks2_reg;
        sn3_reg   <= sn2_reg;
    end

    // Stage 4: 2*ndl*N and the diffuse intensity.
    logic signed [MW-1:0] m4_reg [3];
    logic signed [CB-1:0] v4_reg [3], l4_reg [3];
    logic [VVW-1:0]       vv4_reg;
    side_t                side4_next, side4_reg;
    logic [31+NDLW-1:0]   kp4;

    assign kp4 = kdsh3_reg * ndl3_reg[NDLW-2:0];

    always_comb
    begin
        side4_next.lit    = lit3_reg;
        side4_next.lrgb   = lc3_reg;
        side4_next.amb    = am3_reg;
        side4_next.colp   = colp3_reg;
        side4_next.idiff  = IDW'(kp4 >> (VF - 1));
        side4_next.ks     = ks3_reg;
        side4_next.shadow = sh3_reg;
        side4_next.shin   = sn3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++) begin
            m4_reg[k] <= MW'(2 * ndl3_reg * n3_reg[k]);
            v4_reg[k] <= v3_reg[k];
            l4_reg[k] <= l3_reg[k];
        end
        vv4_reg   <= vv3_reg;
        side4_reg <= side4_next;
    end

    // Stage 5: reflected light direction.
    logic signed [RFW-1:0] rf5_reg [3];
    logic signed [CB-1:0]  v5_reg [3];
    logic [VVW-1:0]        vv5_reg;
    side_t                 side5_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++) begin
            rf5_reg[k] <= RFW'(m4_reg[k] >>> VF) - RFW'(l4_reg[k]);
            v5_reg[k]  <= v4_reg[k];
        end
        vv5_reg   <= vv4_reg;
        side5_reg <= side4_reg;
    end

    // Stage 6: V*R products. Stage 7: V.R.
    logic signed [VRW-1:0]  vr6_reg [3];
    logic [VVW-1:0]         vv6_reg, vv7_reg;
    side_t                  side6_reg, side7_reg;
    logic signed [DVRW-1:0] dvr7_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++) begin
            vr6_reg[k] <= VRW'(v5_reg[k] * rf5_reg[k]);
        end
        vv6_reg   <= vv5_reg;
        side6_reg <= side5_reg;
        dvr7_reg  <= DVRW'(vr6_reg[0]) + DVRW'(vr6_reg[1]) + DVRW'(vr6_reg[2]);
        vv7_reg   <= vv6_reg;
        side7_reg <= side6_reg;
    end

    logic v4_vld_reg, v5_vld_reg, v6_vld_reg, v7_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v2_vld_reg <= 1'b0;
            v3_vld_reg <= 1'b0;
            v4_vld_reg <= 1'b0;
            v5_vld_reg <= 1'b0;
            v6_vld_reg <= 1'b0;
            v7_vld_reg <= 1'b0;
        end else begin
            v2_vld_reg <= v1_reg;
            v3_vld_reg <= v2_vld_reg;
            v4_vld_reg <= v3_vld_reg;
            v5_vld_reg <= v4_vld_reg;
            v6_vld_reg <= v5_vld_reg;
            v7_vld_reg <= v6_vld_reg;
        end
    end

    // Cosine and power units, with the item's other fields alongside.
    logic [COSW-1:0] cosv;
    logic [PWRW-1:0] pwr;
    side_t           dl_reg [DLN];
    logic [DLN-1:0]  vd_reg;

    pls_lendiv u_lendiv (
        .clk     (clk),
        .vv      (vv7_reg),
        .dvr     (dvr7_reg),
        .cos_out (cosv)
    );

    pls_power u_power (
        .clk    (clk),
        .cos_in (cosv),
        .shin   (dl_reg[LAT_DIV-1].shin),
        .pwr    (pwr)
    );

    always_ff @(posedge clk)
    begin
        dl_reg[0] <= side7_reg;
        for (int d = 1; d < DLN; d++) begin
            dl_reg[d] <= dl_reg[d-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vd_reg <= '0;
        end else begin
            vd_reg <= {vd_reg[DLN-2:0], v7_vld_reg};
        end
    end

    // Tail: specular intensity, per-channel terms, final sum.
    logic [46:0]     pk1_reg;
    side_t           t1_reg, t2_reg, t3_reg;
    logic [ISPW-1:0] isp2_reg;
    logic [32:0]     pk_hi;
    logic [48:0]     isp_prod;
    logic [15:0]     d3_reg [3], s3_reg [3];
    logic            t1_vld_reg, t2_vld_reg, t3_vld_reg, done_reg;
    logic [15:0]     red_reg, green_reg, blue_reg;

    assign pk_hi    = pk1_reg[46:14];
    assign isp_prod = pk_hi * t1_reg.shadow;

    always_ff @(posedge clk)
    begin
        pk1_reg  <= pwr * dl_reg[DLN-1].ks;
        t1_reg   <= dl_reg[DLN-1];
        isp2_reg <= isp_prod[48:15];
        t2_reg   <= t1_reg;
        t3_reg   <= t2_reg;
    end

    logic [16+IDW:0]    dp [3];
    logic [15+ISPW:0]   sp [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            dp[k] = t2_reg.colp[k] * t2_reg.idiff;
            sp[k] = t2_reg.lrgb[(2 - k) * 16 +: 16] * isp2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++) begin
            d3_reg[k] <= (dp[k][16+IDW:30] > (IDW - 13)'(ONE_Q15)) ? ONE_Q15
                       : dp[k][45:30];
            s3_reg[k] <= (sp[k][15+ISPW:30] > (ISPW - 14)'(ONE_Q15)) ? ONE_Q15
                       : sp[k][45:30];
        end
    end

    logic [17:0] sum [3];
    logic [15:0] ch  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = 18'(t3_reg.amb[(2 - k) * 16 +: 16]);
            if (t3_reg.lit) begin
                sum[k] = sum[k] + 18'(d3_reg[k]) + 18'(s3_reg[k]);
            end
            ch[k] = (sum[k] > 18'(ONE_Q15)) ? ONE_Q15 : sum[k][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= ch[0];
        green_reg <= ch[1];
        blue_reg  <= ch[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
            t3_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            t1_vld_reg <= vd_reg[DLN-1];
            t2_vld_reg <= t1_vld_reg;
            t3_vld_reg <= t2_vld_reg;
            done_reg   <= t3_vld_reg;
        end
    end

    assign done      = done_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    `PLS_ASSERT_IMPL(a_out_range, done, (red_out <= ONE_Q15) && (green_out <= ONE_Q15) && (blue_out <= ONE_Q15), "result channel above one")
    `PLS_ASSERT_IMPL(a_pow_zero_shin, vd_reg[DLN-1] && (dl_reg[DLN-1].shin == 16'h0000), pwr == PWR_ONE, "zero shininess must give unit power")
    `PLS_ASSERT_ALWAYS(a_never_busy, !busy, "pipeline must accept every cycle")

endmodule

`default_nettype wire

>>> dv/tb_phong_light_shader.sv
// ----------------------------------------------------------------------------
// Phong light shader testbench
// Drives shading points through the command interface, predicts each colour
// in fixed point, and checks every result in order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_phong_light_shader;

    import pls_pkg::*;

    typedef struct {
        logic [47:0] nrm, vw, lt, lrgb, srgb, argb;
        logic [15:0] shadow, kd, ks, shin;
    } point_t;

    typedef struct {
        logic [15:0] r, g, b;
    } colour_t;

    class shade_scoreboard;
        colour_t     pending[$];
        logic [63:0] exp_root[17];
        int          errors;
        int          checked;

        function new();
            exp_root[1] = int_sqrt(64'h1 << 59);
            for (int i = 2; i <= 16; i++)
            begin
                exp_root[i] = int_sqrt(exp_root[i-1] << 30);
            end
        endfunction

        function logic [63:0] int_sqrt(input logic [63:0] x);
            logic [63:0] rem, res, b;
            rem = x;
            res = '0;
            b   = 64'h1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (rem >= res + b)
                begin
                    rem = rem - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // cos^shin in Q1.30; cosine has 14 fraction bits, shin is Q10.6.
        function logic [63:0] cos_power(input logic [63:0] cosv, input logic [63:0] shin);
            logic [63:0] a, lneg, e, f, r, y, frac;
            int          p;
            if (shin == 0)
                return 64'h1 << 30;
            a = cosv << 2;
            if (a == 0)
                return 0;
            if (a >= 65536)
            begin
                lneg = 0;
            end
            else
            begin
                p = 15;
                while (a[p] == 1'b0)
                    p--;
                y    = a << (15 - p);
                frac = 0;
                for (int i = 0; i < 16; i++)
                begin
                    y = (y * y) >> 15;
                    if (y >= 65536)
                    begin
                        y = y >> 1;
                        frac[15-i] = 1'b1;
                    end
                end
                lneg = ((64'(16 - p)) << 16) - frac;
            end
            e = (lneg * shin) >> 6;
            if ((e >> 16) >= 31)
                return 0;
            f = e & 64'hFFFF;
            r = 64'h1 << 30;
            for (int i = 1; i <= 16; i++)
            begin
                if (f[16-i])
                    r = (r * exp_root[i]) >> 30;
            end
            return r >> (e >> 16);
        endfunction

        function colour_t shade(input point_t pt);
            longint      n[3], v[3], l[3], rf[3];
            longint      raw, ndl, dvr, vv;
            logic [63:0] idiff, ispec, len, cosv, lc, sc, amb, d, s, sum;
            logic [63:0] shadow, out[3];
            bit          lit;
            colour_t     c;
            shadow = pt.shadow;
            idiff  = 0;
            ispec  = 0;
            cosv   = 0;
            for (int k = 0; k < 3; k++)
            begin
                n[k] = longint'($signed(pt.nrm[47-16*k -: 16]));
                v[k] = longint'($signed(pt.vw[47-16*k -: 16]));
                l[k] = longint'($signed(pt.lt[47-16*k -: 16]));
            end
            raw = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
            ndl = raw >>> VF;
            lit = (ndl > 0) && (shadow != 0);
            if (lit)
            begin
                idiff = (64'(pt.kd) * shadow * 64'(ndl)) >> (VF - 1);
                for (int k = 0; k < 3; k++)
                    rf[k] = ((2 * ndl * n[k]) >>> VF) - l[k];
                dvr = v[0] * rf[0] + v[1] * rf[1] + v[2] * rf[2];
                vv  = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
                len = int_sqrt(64'(vv));
                if (len != 0 && dvr > 0)
                begin
                    cosv = 64'(dvr) / len;
                    if (cosv > (64'h1 << VF))
                        cosv = 64'h1 << VF;
                end
                ispec = (((cos_power(cosv, 64'(pt.shin)) * 64'(pt.ks)) >> 14) * shadow) >> 15;
            end
            for (int k = 0; k < 3; k++)
            begin
                lc  = 64'(pt.lrgb[47-16*k -: 16]);
                sc  = 64'(pt.srgb[47-16*k -: 16]);
                amb = 64'(pt.argb[47-16*k -: 16]);
                d   = 0;
                s   = 0;
                if (lit)
                begin
                    d = (((lc * sc) >> 15) * idiff) >> 30;
                    if (d > 32768)
                        d = 32768;
                    s = (lc * ispec) >> 30;
                    if (s > 32768)
                        s = 32768;
                end
                sum = amb + d + s;
                if (sum > 32768)
                    sum = 32768;
                out[k] = sum;
            end
            c.r = out[0][15:0];
            c.g = out[1][15:0];
            c.b = out[2][15:0];
            return c;
        endfunction

        function void note_point(input point_t pt);
            pending.push_back(shade(pt));
        endfunction

        function void check_colour(input logic [15:0] r, g, b);
            colour_t e;
            if (pending.size() == 0)
            begin
                $error("result with no point outstanding: r=%0d g=%0d b=%0d", r, g, b);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (r !== e.r)
            begin
                $error("red_out expected %0d actual %0d", e.r, r);
                errors++;
            end
            if (g !== e.g)
            begin
                $error("green_out expected %0d actual %0d", e.g, g);
                errors++;
            end
            if (b !== e.b)
            begin
                $error("blue_out expected %0d actual %0d", e.b, b);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [47:0] normal_vec = '0, view_vec = '0, light_vec = '0;
    logic [47:0] light_rgb = '0, surface_rgb = '0, ambient_rgb = '0;
    logic [15:0] shadow_factor = '0, diffuse_weight = '0, specular_weight = '0;
    logic [15:0] shininess = '0;
    logic        done;
    logic [15:0] red_out, green_out, blue_out;

    shade_scoreboard sb = new();
    int              idle_pct;
    int              quiet_cycles;
    int              sent;

    localparam int QUIET_LIMIT = 5000;

    phong_light_shader DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .normal_vec      (normal_vec),
        .view_vec        (view_vec),
        .light_vec       (light_vec),
        .light_rgb       (light_rgb),
        .surface_rgb     (surface_rgb),
        .ambient_rgb     (ambient_rgb),
        .shadow_factor   (shadow_factor),
        .diffuse_weight  (diffuse_weight),
        .specular_weight (specular_weight),
        .shininess       (shininess),
        .done            (done),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_colour(red_out, green_out, blue_out);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("phong_light_shader regression: fail");
            $finish;
        end
    end

    function automatic logic [47:0] pack_vec(input int x, input int y, input int z);
        return {x[15:0], y[15:0], z[15:0]};
    endfunction

    function automatic int near_comp(input int base, input int spread);
        int t;
        t = base + $urandom_range(2 * spread) - spread;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t;
    endfunction

    function automatic logic [47:0] rand_rgb();
        if ($urandom_range(9) == 0)
            return 48'({$urandom, $urandom});
        return {16'($urandom_range(32768)), 16'($urandom_range(32768)),
                16'($urandom_range(32768))};
    endfunction

    // Lit geometry most of the time: light near the normal, view near the
    // mirror direction, so the specular power path sees real cosines.
    function automatic point_t rand_point();
        point_t pt;
        int     nx, ny, nz;
        nx = $urandom_range(32768) - 16384;
        ny = $urandom_range(32768) - 16384;
        nz = $urandom_range(32768) - 16384;
        pt.nrm  = pack_vec(nx, ny, nz);
        pt.lt   = pack_vec(near_comp(nx, 4000), near_comp(ny, 4000), near_comp(nz, 4000));
        pt.vw   = pack_vec(near_comp(nx, 6000), near_comp(ny, 6000), near_comp(nz, 6000));
        pt.lrgb = rand_rgb();
        pt.srgb = rand_rgb();
        pt.argb = {16'($urandom_range(12000)), 16'($urandom_range(12000)),
                   16'($urandom_range(12000))};
        pt.shadow = 16'($urandom_range(32768));
        pt.kd     = 16'($urandom_range(20000));
        pt.ks     = 16'($urandom_range(20000));
        pt.shin   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4096));
        case ($urandom_range(9))
            0: begin
                pt.nrm = 48'({$urandom, $urandom});
                pt.vw  = 48'({$urandom, $urandom});
                pt.lt  = 48'({$urandom, $urandom});
            end
            1: begin
                pt.shadow = 16'($urandom);
                pt.kd     = 16'($urandom);
                pt.ks     = 16'($urandom);
                pt.argb   = 48'({$urandom, $urandom});
            end
            2: pt.shadow = '0;
            default: ;
        endcase
        return pt;
    endfunction

    task automatic send_point(input point_t pt);
        bit taken;
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start           = 1'b1;
        normal_vec      = pt.nrm;
        view_vec        = pt.vw;
        light_vec       = pt.lt;
        light_rgb       = pt.lrgb;
        surface_rgb     = pt.srgb;
        ambient_rgb     = pt.argb;
        shadow_factor   = pt.shadow;
        diffuse_weight  = pt.kd;
        specular_weight = pt.ks;
        shininess       = pt.shin;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            if (taken)
                sb.note_point(pt);
            @(negedge clk);
        end
        sent++;
    endtask

    task automatic drain();
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic directed_points();
        point_t pt;
        point_t base;
        base.nrm  = pack_vec(0, 0, 16384);
        base.lt   = pack_vec(0, 0, 16384);
        base.vw   = pack_vec(0, 0, 16384);
        base.lrgb = {3{16'd32768}};
        base.srgb = {3{16'd32768}};
        base.argb = {16'd1000, 16'd2000, 16'd3000};
        base.shadow = 16'd32768;
        base.kd   = 16'd8192;
        base.ks   = 16'd8192;
        base.shin = 16'd640;
        // All fields zero, then all fields at their top bit patterns.
        pt = '{default: '0};
        send_point(pt);
        pt = '{nrm: '1, vw: '1, lt: '1, lrgb: '1, srgb: '1, argb: '1,
               shadow: '1, kd: '1, ks: '1, shin: '1};
        send_point(pt);
        send_point(base);
        // Facing away from the light.
        pt = base; pt.lt = pack_vec(0, 0, -16384); send_point(pt);
        // Fully shadowed.
        pt = base; pt.shadow = '0; send_point(pt);
        // Zero-length view vector.
        pt = base; pt.vw = '0; send_point(pt);
        // Long view vector on the mirror direction: cosine reaches one.
        pt = base; pt.vw = pack_vec(0, 0, 32767); send_point(pt);
        pt = base; pt.nrm = pack_vec(32767, 32767, 32767);
        pt.lt = pack_vec(32767, 32767, 32767); pt.vw = pack_vec(-32768, 100, 32767);
        send_point(pt);
        // Zero cosine, with and without zero shininess.
        pt = base; pt.vw = pack_vec(16384, 0, 0); send_point(pt);
        pt.shin = '0; send_point(pt);
        // Zero shininess with a normal cosine: the power is exactly one.
        pt = base; pt.vw = pack_vec(3000, 0, 16000); pt.shin = '0; send_point(pt);
        // Tiny cosine with a huge exponent underflows to zero.
        pt = base; pt.vw = pack_vec(16384, 0, 20); pt.shin = 16'hFFFF; send_point(pt);
        pt.shin = 16'd64; send_point(pt);
        // Shadow factor above one is used as given.
        pt = base; pt.shadow = 16'hFFFF; send_point(pt);
        pt.shadow = 16'd32769; send_point(pt);
        // Weights and colours at their limits.
        pt = base; pt.kd = '1; pt.ks = '1; send_point(pt);
        pt = base; pt.argb = {3{16'd32768}}; send_point(pt);
        pt = base; pt.argb = '1; pt.lrgb = '1; pt.srgb = '1; send_point(pt);
        pt = base; pt.nrm = pack_vec(-32768, -32768, -32768);
        pt.lt = pack_vec(-32768, -32768, -32768); pt.vw = pack_vec(-16384, 0, 0);
        send_point(pt);
        pt = base; pt.lt = pack_vec(1, 0, 0); send_point(pt);
    endtask

    initial
    begin
        idle_pct = 0;
        sent     = 0;
        quiet_cycles = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        directed_points();
        drain();
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
            for (int i = 0; i < 530; i++)
                send_point(rand_point());
            // Hold the sender until the pipeline has emptied.
            drain();
        end
        start = 1'b0;
        repeat (100) @(negedge clk);
        $display("sent %0d shading points (directed corners, then three idle mixes);",
                 sent);
        $display("checked %0d colours, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("phong_light_shader regression: pass");
        else
            $display("phong_light_shader regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/pls_pkg.sv
hdl/pls_lendiv.sv
hdl/pls_power.sv
hdl/phong_light_shader.sv
dv/tb_phong_light_shader.sv
